/* rtl/core/radial_shell_density_histogram_assert.svh */
`ifndef RADIAL_SHELL_DENSITY_HISTOGRAM_ASSERT_SVH
`define RADIAL_SHELL_DENSITY_HISTOGRAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSDH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsdh same-cycle check failed");

// next-cycle implication
`define RSDH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsdh next-cycle check failed");

`endif

/* rtl/core/rsdh_pkg.sv */
package rsdh_pkg;

  localparam int MAX_PARTICLES_DEF = 4096;
  localparam int SHELL_COUNT_DEF   = 41;

  localparam int RADIUS_W = 27;
  localparam int SQ_W     = 54;
  localparam int DIST_W   = 28;
  localparam int D2_W     = 56;
  localparam int M_W      = 14;
  localparam int PM_W     = 44;
  localparam int W2_W     = 40;
  localparam int W3_W     = 60;
  localparam int DEN_W    = 104;
  localparam int DS_W     = 136;
  localparam int STORE_W  = 98;

  localparam logic [29:0] PI_Q28 = 30'd843314857;

  localparam logic [30:0] BOX_RESET   = 31'd655360;
  localparam logic [19:0] WIDTH_RESET = 20'd16384;

  localparam logic [6:0] CDIV_LAST = 7'd63;
  localparam logic [6:0] MUL_LAST  = 7'd43;
  localparam logic [6:0] DIV_LAST  = 7'd32;

  localparam logic [1:0] REG_BOX_X   = 2'd0;
  localparam logic [1:0] REG_BOX_Y   = 2'd1;
  localparam logic [1:0] REG_BOX_Z   = 2'd2;
  localparam logic [1:0] REG_SHELL_W = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        particle_mass;
    logic               in_center_group;
    logic               is_coion;
    logic               is_counterion;
    logic               last_particle;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  shell_number;
    logic [30:0] outer_radius;
    logic [12:0] coion_count;
    logic [12:0] counterion_count;
    logic [31:0] coion_density;
    logic [31:0] counterion_density;
    logic        last_shell;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       cdiv_load;
    logic       cdiv_step;
    logic       cdiv_store;
    logic [1:0] axis;
    logic       w_sq;
    logic       w_cube;
    logic       shell_sq;
    logic       scan_run;
    logic       mul_load;
    logic       mul_step;
    logic       dv_load;
    logic       dv_sel;
    logic       dv_step;
    logic       dv_store;
    logic       shell_next;
    logic       frame_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

/* rtl/core/radial_shell_density_histogram.sv */
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------
// input     | start, busy (taken: start&!busy)| in_word (in_word_t)
// result    | out_valid, one-cycle strobe    | out_word (out_word_t)
// config    | psel/penable/pwrite, pready=1  | paddr[3:2], pwdata, prdata
//
// A particle without last_particle is loaded while busy stays low.
// The closing particle starts the frame pass: the center divider for each
// axis, the w squared and w cubed setup, then per shell the store scan
// (one particle per cycle through the RAM read port), the shift-add multiply
// and the coion and counterion divisions, then the result word.
// rst_n is synchronous; the receiver cannot stall results.
module radial_shell_density_histogram import rsdh_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int SHELL_COUNT   = SHELL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] box_x_r, box_y_r, box_z_r;
  logic [19:0] shell_w_r;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [5:0]  shell_idx;
  logic        last_shell;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r   <= BOX_RESET;
      box_y_r   <= BOX_RESET;
      box_z_r   <= BOX_RESET;
      shell_w_r <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BOX_X:   box_x_r   <= pwdata[30:0];
        REG_BOX_Y:   box_y_r   <= pwdata[30:0];
        REG_BOX_Z:   box_z_r   <= pwdata[30:0];
        REG_SHELL_W: shell_w_r <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BOX_X:   prdata = {1'b0, box_x_r};
      REG_BOX_Y:   prdata = {1'b0, box_y_r};
      REG_BOX_Z:   prdata = {1'b0, box_z_r};
      REG_SHELL_W: prdata = {12'b0, shell_w_r};
      default:     prdata = '0;
    endcase
  end

  rsdh_ctrl #(.SHELL_COUNT(SHELL_COUNT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_in    (in_word.last_particle),
    .busy       (busy),
    .out_valid  (out_valid),
    .shell_idx  (shell_idx),
    .last_shell (last_shell),
    .cmd        (cmd),
    .stat       (stat)
  );

  rsdh_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_word    (in_word),
    .box_x      (box_x_r),
    .box_y      (box_y_r),
    .box_z      (box_z_r),
    .shell_w    (shell_w_r),
    .shell_idx  (shell_idx),
    .last_shell (last_shell),
    .out_word   (out_word)
  );

endmodule

/* rtl/core/rsdh_ram.sv */
module rsdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rsdh_ctrl.sv */
module rsdh_ctrl import rsdh_pkg::*; #(
  parameter int SHELL_COUNT = SHELL_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       last_in,
  output logic       busy,
  output logic       out_valid,
  output logic [5:0] shell_idx,
  output logic       last_shell,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLOAD  = 12'b000000000010,
    S_CRUN   = 12'b000000000100,
    S_CSTORE = 12'b000000001000,
    S_WSQ    = 12'b000000010000,
    S_WCUBE  = 12'b000000100000,
    S_SHSQ   = 12'b000001000000,
    S_SCAN   = 12'b000010000000,
    S_MUL    = 12'b000100000000,
    S_DLOAD  = 12'b001000000000,
    S_DIV    = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  localparam logic [5:0] SHELL_LAST = 6'(SHELL_COUNT - 1);

  state_t     state_r, state_nxt;
  logic [6:0] step_r, step_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [5:0] shell_r, shell_nxt;
  logic       sel_r, sel_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    axis_nxt     = axis_r;
    shell_nxt    = shell_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.dv_sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_in) begin
            axis_nxt  = AXIS_X;
            state_nxt = S_CLOAD;
          end
        end
      end
      S_CLOAD: begin
        cmd.cdiv_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_CRUN;
      end
      S_CRUN: begin
        cmd.cdiv_step = 1'b1;
        step_nxt      = step_r + 7'd1;
        if (step_r == CDIV_LAST) begin
          state_nxt = S_CSTORE;
        end
      end
      S_CSTORE: begin
        cmd.cdiv_store = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_WSQ;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_CLOAD;
        end
      end
      S_WSQ: begin
        cmd.w_sq  = 1'b1;
        shell_nxt = '0;
        state_nxt = S_WCUBE;
      end
      S_WCUBE: begin
        cmd.w_cube = 1'b1;
        state_nxt  = S_SHSQ;
      end
      S_SHSQ: begin
        cmd.shell_sq = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          cmd.mul_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r + 7'd1;
        if (step_r == MUL_LAST) begin
          sel_nxt   = 1'b0;
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.dv_load = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.dv_step = 1'b1;
        step_nxt    = step_r + 7'd1;
        if (step_r == DIV_LAST) begin
          cmd.dv_store = 1'b1;
          if (sel_r) begin
            state_nxt = S_EMIT;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = S_DLOAD;
          end
        end
      end
      S_EMIT: begin
        if (shell_r == SHELL_LAST) begin
          cmd.frame_clear = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.shell_next = 1'b1;
          shell_nxt      = shell_r + 6'd1;
          state_nxt      = S_SHSQ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // the second division's store lands on the edge entering S_EMIT
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      axis_r     <= AXIS_X;
      shell_r    <= '0;
      sel_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      axis_r     <= axis_nxt;
      shell_r    <= shell_nxt;
      sel_r      <= sel_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_EMIT);
  assign shell_idx  = shell_r;
  assign last_shell = (shell_r == SHELL_LAST);

endmodule

/* rtl/core/rsdh_dp.sv */
module rsdh_dp import rsdh_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  in_word_t    in_word,
  input  logic [30:0] box_x,
  input  logic [30:0] box_y,
  input  logic [30:0] box_z,
  input  logic [19:0] shell_w,
  input  logic [5:0]  shell_idx,
  input  logic        last_shell,
  output out_word_t   out_word
);

  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int TMW   = CW + 16;
  localparam int NUM_W = CW + 92;

  function automatic logic [DIST_W-1:0] axis_dist(
    input logic signed [31:0] p,
    input logic signed [31:0] c,
    input logic [30:0]        len,
    input logic [RADIUS_W-1:0] outer
  );
    logic signed [33:0] d;
    logic signed [33:0] a;
    logic signed [33:0] lim;
    logic signed [33:0] e;
    d   = $signed({{2{p[31]}}, p}) - $signed({{2{c[31]}}, c});
    a   = (d < 0) ? -d : d;
    lim = $signed({3'b0, len}) - $signed({7'b0, outer});
    if (a > lim) begin
      e = $signed({3'b0, len}) - d;
      a = (e < 0) ? -e : e;
    end
    return (a > 34'sd134217728) ? 28'd134217728 : a[DIST_W-1:0];
  endfunction

  // load and center-of-mass sums
  logic [CW-1:0]   loaded_r;
  logic [63:0]     sum_x_r, sum_y_r, sum_z_r;
  logic [TMW-1:0]  tm_r;
  logic            store_open, we;
  logic signed [48:0] prod_x, prod_y, prod_z;
  logic [STORE_W-1:0] wdata, rdata;

  assign store_open = (loaded_r < CW'(MAX_PARTICLES));
  assign we         = cmd.load && store_open;
  assign prod_x     = in_word.pos_x * $signed({1'b0, in_word.particle_mass});
  assign prod_y     = in_word.pos_y * $signed({1'b0, in_word.particle_mass});
  assign prod_z     = in_word.pos_z * $signed({1'b0, in_word.particle_mass});
  assign wdata      = {in_word.pos_x, in_word.pos_y, in_word.pos_z,
                       in_word.is_counterion, in_word.is_coion};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.frame_clear) begin
      loaded_r <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_z_r  <= '0;
      tm_r     <= '0;
    end else if (we) begin
      loaded_r <= loaded_r + 1'b1;
      if (in_word.in_center_group) begin
        sum_x_r <= sum_x_r + {{15{prod_x[48]}}, prod_x};
        sum_y_r <= sum_y_r + {{15{prod_y[48]}}, prod_y};
        sum_z_r <= sum_z_r + {{15{prod_z[48]}}, prod_z};
        tm_r    <= tm_r + TMW'(in_word.particle_mass);
      end
    end
  end

  // scan index
  logic [CW-1:0] scan_idx_r;
  logic          issue;

  assign issue = cmd.scan_run && (scan_idx_r < loaded_r);

  rsdh_ram #(.WIDTH(STORE_W), .DEPTH(MAX_PARTICLES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (loaded_r[AW-1:0]),
    .wdata (wdata),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // center division, one quotient bit per cycle
  logic [63:0]       sum_sel, mag;
  logic [63:0]       cq_r;
  logic [TMW-1:0]    crem_r;
  logic              cneg_r;
  logic [TMW:0]      crem_sh;
  logic              cge;
  logic signed [31:0] cres;
  logic signed [31:0] cx_r, cy_r, cz_r;

  always_comb begin
    case (cmd.axis)
      AXIS_X:  sum_sel = sum_x_r;
      AXIS_Y:  sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
    mag     = sum_sel[63] ? (64'd0 - sum_sel) : sum_sel;
    crem_sh = {crem_r, cq_r[63]};
    cge     = (crem_sh >= {1'b0, tm_r});
    if (tm_r == '0) begin
      cres = '0;
    end else if (cneg_r) begin
      cres = (cq_r > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - cq_r[31:0]);
    end else begin
      cres = (cq_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(cq_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cdiv_load) begin
      cq_r   <= mag;
      crem_r <= '0;
      cneg_r <= sum_sel[63];
    end else if (cmd.cdiv_step) begin
      crem_r <= cge ? TMW'(crem_sh - {1'b0, tm_r}) : crem_sh[TMW-1:0];
      cq_r   <= {cq_r[62:0], cge};
    end
    if (cmd.cdiv_store) begin
      case (cmd.axis)
        AXIS_X:  cx_r <= cres;
        AXIS_Y:  cy_r <= cres;
        default: cz_r <= cres;
      endcase
    end
  end

  // shell geometry
  logic [W2_W-1:0]     w2_r;
  logic [W3_W-1:0]     w3_r;
  logic [RADIUS_W-1:0] inner_r, outer_r;
  logic [SQ_W-1:0]     inner2_r, outer2_r;
  logic [M_W-1:0]      m_r;
  logic [PM_W-1:0]     pm_r;
  logic [6:0]          kp;
  logic [M_W-1:0]      m_inc;

  assign kp    = {1'b0, shell_idx} + 7'd1;
  assign m_inc = M_W'({kp, 2'b0}) + M_W'({kp, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.w_sq) begin
      w2_r     <= shell_w * shell_w;
      inner_r  <= '0;
      outer_r  <= RADIUS_W'(shell_w);
      inner2_r <= '0;
      m_r      <= M_W'(1);
    end
    if (cmd.w_cube) begin
      w3_r <= w2_r * shell_w;
    end
    if (cmd.shell_sq) begin
      outer2_r <= outer_r * outer_r;
      pm_r     <= PI_Q28 * m_r;
    end
    if (cmd.shell_next) begin
      inner_r  <= outer_r;
      outer_r  <= outer_r + RADIUS_W'(shell_w);
      inner2_r <= outer2_r;
      m_r      <= m_r + m_inc;
    end
  end

  // scan pipeline: read, axis distances, squares, compare
  logic              v1_r, v2_r, v3_r;
  logic [DIST_W-1:0] ax_r, ay_r, az_r;
  logic [1:0]        g2_r, g3_r;
  logic [D2_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [D2_W-1:0]   d2;
  logic              hit;
  logic [CW-1:0]     co_cnt_r, ct_cnt_r;

  assign d2  = sqx_r + sqy_r + sqz_r;
  assign hit = v3_r && (d2 >= D2_W'(inner2_r)) && (d2 < D2_W'(outer2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shell_sq) begin
      scan_idx_r <= '0;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    ax_r  <= axis_dist($signed(rdata[97:66]), cx_r, box_x, outer_r);
    ay_r  <= axis_dist($signed(rdata[65:34]), cy_r, box_y, outer_r);
    az_r  <= axis_dist($signed(rdata[33:2]), cz_r, box_z, outer_r);
    g2_r  <= rdata[1:0];
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
    sqz_r <= az_r * az_r;
    g3_r  <= g2_r;
    if (cmd.shell_sq) begin
      co_cnt_r <= '0;
      ct_cnt_r <= '0;
    end else if (hit) begin
      if (g3_r[0]) begin
        co_cnt_r <= co_cnt_r + 1'b1;
      end
      if (g3_r[1]) begin
        ct_cnt_r <= ct_cnt_r + 1'b1;
      end
    end
  end

  assign stat.scan_done = !(scan_idx_r < loaded_r) && !v1_r && !v2_r && !v3_r;

  // shell volume denominator, shift-add over the bits of pi*m
  logic [PM_W-1:0]  ma_r;
  logic [DEN_W-1:0] mb_r, acc_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_r  <= pm_r;
      mb_r  <= DEN_W'(w3_r);
      acc_r <= '0;
    end else if (cmd.mul_step) begin
      if (ma_r[0]) begin
        acc_r <= acc_r + mb_r;
      end
      ma_r <= ma_r >> 1;
      mb_r <= mb_r << 1;
    end
  end

  // density division, 33 quotient bits, top bit means saturate
  logic [NUM_W-1:0] rem_r;
  logic [DS_W-1:0]  ds_r;
  logic [31:0]      dq_r;
  logic [32:0]      dq_fin;
  logic [CW+1:0]    cnt3;
  logic [CW-1:0]    cnt_sel;
  logic             dge;
  logic [31:0]      dres;
  logic [31:0]      dco_r, dct_r;

  assign cnt_sel = cmd.dv_sel ? ct_cnt_r : co_cnt_r;
  assign cnt3    = {2'b0, cnt_sel} + {1'b0, cnt_sel, 1'b0};
  assign dge     = (DS_W'(rem_r) >= ds_r) && (rem_r != '0);
  assign dq_fin  = {dq_r, dge};
  assign dres    = dq_fin[32] ? 32'hFFFF_FFFF : dq_fin[31:0];

  always_ff @(posedge clk) begin
    if (cmd.dv_load) begin
      rem_r <= {cnt3, 90'b0};
      ds_r  <= {acc_r, 32'b0};
      dq_r  <= '0;
    end else if (cmd.dv_step) begin
      rem_r <= dge ? NUM_W'(DS_W'(rem_r) - ds_r) : rem_r;
      ds_r  <= ds_r >> 1;
      dq_r  <= {dq_r[30:0], dge};
    end
    if (cmd.dv_store) begin
      if (cmd.dv_sel) begin
        dct_r <= dres;
      end else begin
        dco_r <= dres;
      end
    end
  end

  assign out_word.shell_number       = shell_idx;
  assign out_word.outer_radius       = 31'(outer_r);
  assign out_word.coion_count        = 13'(co_cnt_r);
  assign out_word.counterion_count   = 13'(ct_cnt_r);
  assign out_word.coion_density      = dco_r;
  assign out_word.counterion_density = dct_r;
  assign out_word.last_shell         = last_shell;

endmodule

/* rtl/core/rsdh_checker.sv */
module rsdh_checker import rsdh_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

`include "radial_shell_density_histogram_assert.svh"

  `RSDH_ASSERT_SAME(a_word_only_busy, out_valid, busy)
  `RSDH_ASSERT_NEXT(a_load_stays_free, start && !busy && !in_word.last_particle, !busy)
  `RSDH_ASSERT_NEXT(a_close_goes_busy, start && !busy && in_word.last_particle, busy && !out_valid)
  `RSDH_ASSERT_NEXT(a_words_spaced, out_valid && !out_word.last_shell, !out_valid && busy)
  `RSDH_ASSERT_NEXT(a_frame_ends, out_valid && out_word.last_shell, !busy)

endmodule

bind radial_shell_density_histogram rsdh_checker u_chk (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rsdh_pkg::*;

  localparam int SHELLS         = 41;
  localparam int STORE_DEPTH    = 4096;
  localparam int WATCHDOG_LIMIT = 60000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  radial_shell_density_histogram i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and frame state
  logic [30:0] box_x, box_y, box_z;
  logic [19:0] shell_w;
  in_word_t    held_q[$];
  logic [63:0] wsum_x, wsum_y, wsum_z;
  logic [27:0] mass_total;

  out_word_t shell_expect_q[$];
  int        errors;
  int        idle_pct;
  int        quiet_cycles;

  typedef struct {
    in_word_t w;
    bit       typed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic in_word_t mk(longint x, longint y, longint z, int m,
                                  bit cg, bit co, bit ct, bit last);
    in_word_t w;
    w.pos_x           = x[31:0];
    w.pos_y           = y[31:0];
    w.pos_z           = z[31:0];
    w.particle_mass   = m[15:0];
    w.in_center_group = cg;
    w.is_coion        = co;
    w.is_counterion   = ct;
    w.last_particle   = last;
    return w;
  endfunction

  function automatic longint center_of(logic [63:0] sum);
    logic [63:0] mag, q;
    if (mass_total == 0) return 0;
    mag = sum[63] ? (64'd0 - sum) : sum;
    q = mag / 64'(mass_total);
    if (sum[63]) begin
      if (q > 64'h80000000) q = 64'h80000000;
      return -longint'(q);
    end
    if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
    return longint'(q);
  endfunction

  function automatic longint axis_dist(longint p, longint c, longint len, longint outer);
    longint d, a, e;
    d = p - c;
    a = d < 0 ? -d : d;
    if (a > len - outer) begin
      e = len - d;
      a = e < 0 ? -e : e;
    end
    return a > (longint'(1) << 27) ? (longint'(1) << 27) : a;
  endfunction

  function automatic logic [31:0] shell_density(int cnt, longint unsigned m,
                                                longint unsigned w);
    logic [127:0] num, den, q;
    num = (128'(cnt) * 128'd3) << 90;
    den = 128'(PI_Q28) * 128'(m) * 128'(w) * 128'(w) * 128'(w);
    if (den == 0) return (num == 0) ? 32'd0 : 32'hFFFFFFFF;
    q = num / den;
    if (q > 128'hFFFFFFFF) return 32'hFFFFFFFF;
    return q[31:0];
  endfunction

  task automatic close_frame(bit typed);
    longint    cx, cy, cz, ax, ay, az;
    longint unsigned inner, outer, inner2, outer2, d2, m;
    int        n_co, n_ct;
    out_word_t r;
    cx = center_of(wsum_x);
    cy = center_of(wsum_y);
    cz = center_of(wsum_z);
    for (int k = 0; k < SHELLS; k++) begin
      inner  = k * shell_w;
      outer  = (k + 1) * shell_w;
      inner2 = inner * inner;
      outer2 = outer * outer;
      m      = 3 * k * k + 3 * k + 1;
      n_co   = 0;
      n_ct   = 0;
      foreach (held_q[i]) begin
        if (held_q[i].is_coion || held_q[i].is_counterion) begin
          ax = axis_dist(longint'(held_q[i].pos_x), cx, longint'(box_x), outer);
          ay = axis_dist(longint'(held_q[i].pos_y), cy, longint'(box_y), outer);
          az = axis_dist(longint'(held_q[i].pos_z), cz, longint'(box_z), outer);
          d2 = ax * ax + ay * ay + az * az;
          if (inner2 <= d2 && d2 < outer2) begin
            if (held_q[i].is_coion) n_co++;
            if (held_q[i].is_counterion) n_ct++;
          end
        end
      end
      r.shell_number       = k[5:0];
      r.outer_radius       = outer[30:0];
      r.coion_count        = typed ? 13'd0 : n_co[12:0];
      r.counterion_count   = typed ? 13'd0 : n_ct[12:0];
      r.coion_density      = typed ? 32'd0 : shell_density(n_co, m, shell_w);
      r.counterion_density = typed ? 32'd0 : shell_density(n_ct, m, shell_w);
      r.last_shell         = (k == SHELLS - 1);
      shell_expect_q.push_back(r);
    end
    held_q.delete();
    wsum_x = '0;
    wsum_y = '0;
    wsum_z = '0;
    mass_total = '0;
  endtask

  task automatic take_particle(in_word_t w, bit typed);
    if (held_q.size() < STORE_DEPTH) begin
      held_q.push_back(w);
      if (w.in_center_group) begin
        wsum_x += 64'(longint'(w.pos_x) * longint'(w.particle_mass));
        wsum_y += 64'(longint'(w.pos_y) * longint'(w.particle_mass));
        wsum_z += 64'(longint'(w.pos_z) * longint'(w.particle_mass));
        mass_total += 28'(w.particle_mass);
      end
    end
    if (w.last_particle) close_frame(typed);
  endtask

  // leaves start high; stop_feed lowers it when the next action is not a word
  task automatic feed(in_word_t w, bit typed);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    take_particle(w, typed);
  endtask

  task automatic stop_feed();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_feed();
    while (shell_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BOX_X:   box_x   = val[30:0];
      REG_BOX_Y:   box_y   = val[30:0];
      REG_BOX_Z:   box_z   = val[30:0];
      REG_SHELL_W: shell_w = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
    drain();
    cfg_write(REG_BOX_X, x);
    cfg_write(REG_BOX_Y, y);
    cfg_write(REG_BOX_Z, z);
    cfg_write(REG_SHELL_W, w);
  endtask

  function automatic in_word_t rand_particle(longint ofs, bit last);
    longint span;
    in_word_t w;
    span = 42 * longint'(shell_w) + 1;
    w = mk(0, 0, 0, $urandom_range(0, 65535), $urandom_range(99) < 70,
           $urandom_range(1), $urandom_range(1), last);
    if ($urandom_range(99) < 85) begin
      w.pos_x = 32'(ofs + longint'($urandom_range(0, 32'(2 * span))) - span);
      w.pos_y = 32'(ofs + longint'($urandom_range(0, 32'(2 * span))) - span);
      w.pos_z = 32'(ofs + longint'($urandom_range(0, 32'(2 * span))) - span);
    end else begin
      w.pos_x = $urandom;
      w.pos_y = $urandom;
      w.pos_z = $urandom;
    end
    return w;
  endfunction

  task automatic random_frames(int items);
    int     n, fsize;
    longint ofs;
    n = 0;
    while (n < items) begin
      fsize = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      ofs = longint'($urandom_range(0, 32'h40000)) - 32'h20000;
      for (int i = 0; i < fsize; i++) feed(rand_particle(ofs, i == fsize - 1), 1'b0);
      n += fsize;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (shell_expect_q.size() == 0) begin
        $error("result word with none expected: shell %0d", out_word.shell_number);
        errors++;
      end else begin
        out_word_t e;
        e = shell_expect_q.pop_front();
        if (out_word.shell_number !== e.shell_number) begin
          $error("shell_number exp %0d got %0d", e.shell_number, out_word.shell_number);
          errors++;
        end
        if (out_word.outer_radius !== e.outer_radius) begin
          $error("outer_radius exp %0h got %0h", e.outer_radius, out_word.outer_radius);
          errors++;
        end
        if (out_word.coion_count !== e.coion_count) begin
          $error("coion_count exp %0d got %0d", e.coion_count, out_word.coion_count);
          errors++;
        end
        if (out_word.counterion_count !== e.counterion_count) begin
          $error("counterion_count exp %0d got %0d", e.counterion_count,
                 out_word.counterion_count);
          errors++;
        end
        if (out_word.coion_density !== e.coion_density) begin
          $error("coion_density exp %0h got %0h", e.coion_density, out_word.coion_density);
          errors++;
        end
        if (out_word.counterion_density !== e.counterion_density) begin
          $error("counterion_density exp %0h got %0h", e.counterion_density,
                 out_word.counterion_density);
          errors++;
        end
        if (out_word.last_shell !== e.last_shell) begin
          $error("last_shell exp %0b got %0b", e.last_shell, out_word.last_shell);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    errors     = 0;
    idle_pct   = 0;
    quiet_cycles = 0;
    box_x      = BOX_RESET;
    box_y      = BOX_RESET;
    box_z      = BOX_RESET;
    shell_w    = WIDTH_RESET;
    wsum_x     = '0;
    wsum_y     = '0;
    wsum_z     = '0;
    mass_total = '0;

    // no ion groups: every count and density zero
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 1), 1'b1});
    dir_rows.push_back('{mk(0, 0, 0, 16'hFFFF, 1, 1, 1, 1), 1'b0});
    dir_rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1, 1, 0, 0), 1'b0});
    dir_rows.push_back('{mk(-32'sh80000000, -32'sh80000000, -32'sh80000000, 16'hFFFF, 1, 0, 1, 0),
                         1'b0});
    dir_rows.push_back('{mk(32'h10000, -32'sh10000, 32'h8000, 16'h100, 1, 1, 1, 1), 1'b0});
    // zero total mass leaves the center at the origin
    dir_rows.push_back('{mk(32'h4000, 0, 0, 0, 1, 1, 0, 0), 1'b0});
    dir_rows.push_back('{mk(0, 32'h8000, 0, 0, 1, 0, 1, 1), 1'b0});
    dir_rows.push_back('{mk(32'h50000, 32'h50000, 0, 16'h200, 0, 1, 1, 0), 1'b0});
    dir_rows.push_back('{mk(32'h28000, 0, 0, 16'h100, 1, 1, 1, 1), 1'b0});
    // near the far box face: periodic image lands in an inner shell
    dir_rows.push_back('{mk(32'h9C000, 32'h9E000, 0, 16'h100, 0, 1, 0, 0), 1'b0});
    dir_rows.push_back('{mk(0, 0, 0, 16'h100, 1, 0, 1, 1), 1'b0});
    dir_rows.push_back('{mk(-32'sh30000, -32'sh18000, 32'h4000, 16'h80, 1, 1, 0, 0), 1'b0});
    dir_rows.push_back('{mk(-32'sh10000, 32'h20000, -32'sh8000, 16'h180, 1, 0, 1, 1), 1'b0});
    dir_rows.push_back('{mk(32'h12345678, -32'sh5A5A5A5A, 32'h0F0F0F0F, 16'hA5A5, 1, 0, 0, 1),
                         1'b1});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) feed(dir_rows[i].w, dir_rows[i].typed);

    idle_pct = 0;
    random_frames(40);

    set_config(32'd1, 32'd1, 32'd1, 32'd1);
    idle_pct = 51;
    random_frames(35);

    set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFF);
    idle_pct = 22;
    random_frames(35);

    // zero shell width
    set_config(32'h60000, 32'h50000, 32'h70000, 32'd0);
    idle_pct = 0;
    feed(mk(0, 0, 0, 0, 0, 1, 1, 0), 1'b1);
    feed(mk(32'h100, 0, 0, 16'h100, 1, 1, 1, 1), 1'b1);

    set_config(32'h60000, 32'h48000, 32'h30000, 32'h2000);
    idle_pct = 51;
    random_frames(30);
    stop_feed();
    while (shell_expect_q.size() != 0) @(posedge clk);
    random_frames(30);

    set_config($urandom_range(1, 32'h7FFFFFFF), $urandom_range(1, 32'h7FFFFFFF),
               $urandom_range(1, 32'h7FFFFFFF), $urandom_range(1, 32'hFFFFF));
    idle_pct = 22;
    random_frames(35);

    set_config(BOX_RESET, BOX_RESET, BOX_RESET, WIDTH_RESET);
    idle_pct = 0;
    random_frames(30);

    stop_feed();
    while (shell_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rsdh_pkg.sv
rtl/core/rsdh_ram.sv
rtl/core/rsdh_ctrl.sv
rtl/core/rsdh_dp.sv
rtl/core/radial_shell_density_histogram.sv
rtl/core/rsdh_checker.sv
test/tb_top.sv
